// ----- rtl/prvs_pkg.sv -----
// prvs_pkg: constants, codes and helper functions of the page replacement victim selector
// no dependencies; imported by the core and the bench
`timescale 1ns / 1ps
`default_nettype none
package prvs_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int AGE_BITS   = 32;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = $clog2(NUM_FRAMES);
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int RAM_W      = AGE_BITS + TIME_W;
  localparam int VAL_W      = (AGE_BITS > TIME_W) ? AGE_BITS : TIME_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;

  // request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_ACCESS = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_VICTIM    = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_UNTRACKED = 2'd3;

  // replacement policies
  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_CLOCK = 3'd1;
  localparam logic [2:0] POL_NRU   = 3'd2;
  localparam logic [2:0] POL_AGING = 3'd3;
  localparam logic [2:0] POL_WSET  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NRU_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WS_TAU     = 2'd2;

  // slot holding queue position pos
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W+1-SLOT_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W+1)'(NUM_FRAMES)) begin
      sum = sum - (CNT_W+1)'(NUM_FRAMES);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // queue position after pos, wrapping at the fill count
  function automatic logic [CNT_W-1:0] next_pos(input logic [CNT_W-1:0] pos,
                                                 input logic [CNT_W-1:0] count);
    logic [CNT_W:0] nxt;
    nxt = {1'b0, pos} + (CNT_W+1)'(1);
    return (nxt >= {1'b0, count}) ? '0 : nxt[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/prvs_req_if.sv -----
// prvs_req_if: request channel (valid, ready, request fields)
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface prvs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  frame_index;
  logic        is_write;
  logic [31:0] instr_count;
  modport source (output valid, mode, frame_index, is_write, instr_count, input ready);
  modport sink (input valid, mode, frame_index, is_write, instr_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/prvs_rsp_if.sv -----
// prvs_rsp_if: result channel (valid, ready, status and victim frame)
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface prvs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] victim_frame;
  modport source (output valid, status, victim_frame, input ready);
  modport sink (input valid, status, victim_frame, output ready);
endinterface
`default_nettype wire

// ----- rtl/prvs_ram.sv -----
// prvs_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module prvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/page_replacement_victim_selector_core.sv -----
// page_replacement_victim_selector_core: frame queue with fifo, clock, nru, aging
// and working set victim selection; uses prvs_pkg, prvs_req_if, prvs_rsp_if, prvs_ram
//
//   channel  | dir | handshake          | payload
//   req      | in  | req.valid/ready    | mode, frame_index, is_write, instr_count
//   rsp      | out | rsp.valid/ready    | status, victim_frame
//   cfg      | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
// insert, access, fifo select, empty select and unused mode go straight to S_DONE.
// clock, nru and working set select scan the queued frames from the hand;
// aging makes a shift pass then a search pass over the one read port.
// rst is synchronous and resets the control state; a slot's ram entry is
// always written on insert before any scan reads it.
// a request is taken only in idle; a finished result stalls in S_DONE until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none
module page_replacement_victim_selector_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  prvs_req_if.sink                            req,
  prvs_rsp_if.source                          rsp,
  input  wire logic                           cfg_we,
  input  wire logic [prvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prvs_pkg::CFG_W-1:0]     cfg_data
);
  import prvs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLOCK = 7'b0000010,
    S_NRU   = 7'b0000100,
    S_AGE1  = 7'b0001000,
    S_AGE2  = 7'b0010000,
    S_WSET  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [2:0]            policy;
  logic [TIME_W-1:0]     nru_clear_period;
  logic [TIME_W-1:0]     working_set_tau;
  logic [NUM_FRAMES-1:0] frame_queued;
  logic [NUM_FRAMES-1:0] slot_referenced;
  logic [NUM_FRAMES-1:0] slot_modified;
  logic [SLOT_W-1:0]     slot_frame [NUM_FRAMES];
  logic [SLOT_W-1:0]     frame_slot [NUM_FRAMES];
  logic [SLOT_W-1:0]     queue_head;
  logic [CNT_W-1:0]      queue_count;
  logic [CNT_W-1:0]      scan_hand;
  logic [TIME_W-1:0]     last_clear_time;
  logic [TIME_W-1:0]     now_time;
  logic [CNT_W-1:0]      issue_cnt;
  logic [CNT_W-1:0]      issue_pos;
  logic                  eval_valid;
  logic [CNT_W-1:0]      eval_pos;
  logic [SLOT_W-1:0]     eval_slot;
  logic [CNT_W-1:0]      best_pos;
  logic [VAL_W-1:0]      best_val;
  logic [2:0]            best_cls;
  logic                  have_best;
  logic [1:0]            res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [3:0]            out_frame;

  // ram: age in the upper field, last-use time in the lower field
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [RAM_W-1:0]      ram_rdata;
  logic [AGE_BITS-1:0]   rd_age;
  logic [TIME_W-1:0]     rd_last_use;

  logic                  accept;
  logic                  in_range;
  logic [SLOT_W-1:0]     frame_idx;
  logic [SLOT_W-1:0]     ins_slot;
  logic                  ins_append;
  logic [CNT_W-1:0]      start_pos;
  logic                  issue_more;
  logic                  eval_last;
  logic [SLOT_W-1:0]     hand_slot;
  logic [SLOT_W-1:0]     walk_slot;
  logic [2:0]            nru_cls;
  logic [CNT_W-1:0]      nru_pos;
  logic [TIME_W-1:0]     idle_raw;
  logic                  ws_ref;
  logic                  ws_hit;
  logic [VAL_W-1:0]      cand_val;
  logic                  take;
  logic [CNT_W-1:0]      keep_pos;
  logic                  out_free;
  logic [1:0]            acc_status;
  state_t                acc_state;

  prvs_ram #(.WIDTH(RAM_W), .DEPTH(NUM_FRAMES)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.victim_frame = out_frame;
  assign out_free     = !out_valid || rsp.ready;

  // request decode
  assign in_range   = int'(req.frame_index) < NUM_FRAMES;
  assign frame_idx  = req.frame_index[SLOT_W-1:0];
  assign ins_append = !frame_queued[frame_idx];
  assign ins_slot   = ins_append ? slot_of(queue_head, queue_count) : frame_slot[frame_idx];
  assign start_pos  = (scan_hand >= queue_count) ? '0 : scan_hand;

  // status and next state of an accepted request
  always_comb begin
    acc_status = ST_DONE;
    acc_state  = S_DONE;
    case (req.mode)
      MODE_INSERT: begin
        if (!in_range) begin
          acc_status = ST_UNTRACKED;
        end
      end
      MODE_ACCESS: begin
        if (!(in_range && frame_queued[frame_idx])) begin
          acc_status = ST_UNTRACKED;
        end
      end
      MODE_SELECT: begin
        if (queue_count == '0) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_status = ST_VICTIM;
          case (policy)
            POL_CLOCK: acc_state = S_CLOCK;
            POL_NRU:   acc_state = S_NRU;
            POL_AGING: acc_state = S_AGE1;
            POL_WSET:  acc_state = S_WSET;
            default:   acc_state = S_DONE;
          endcase
        end
      end
      default: ;
    endcase
  end

  // scan helpers
  assign issue_more = issue_cnt < queue_count;
  assign eval_last  = eval_valid && !issue_more;
  assign hand_slot  = slot_of(queue_head, scan_hand);
  assign walk_slot  = slot_of(queue_head, issue_pos);
  assign nru_cls    = {1'b0, slot_referenced[walk_slot], slot_modified[walk_slot]};
  assign nru_pos    = (nru_cls < best_cls) ? issue_pos : best_pos;
  assign rd_age      = ram_rdata[RAM_W-1:TIME_W];
  assign rd_last_use = ram_rdata[TIME_W-1:0];
  assign idle_raw    = now_time - rd_last_use;
  assign ws_ref      = slot_referenced[eval_slot];
  assign ws_hit      = !ws_ref && (idle_raw >= working_set_tau);

  // candidate compare for aging (least age) and working set (largest idle)
  always_comb begin
    if (state == S_AGE2) begin
      cand_val = VAL_W'(rd_age);
      take     = !have_best || (cand_val < best_val);
    end else begin
      cand_val = ws_ref ? '0 : VAL_W'(idle_raw);
      take     = !have_best || (cand_val > best_val);
    end
    keep_pos = take ? eval_pos : best_pos;
  end

  // ram ports
  always_comb begin
    ram_raddr = (state == S_AGE1) ? slot_of(queue_head, issue_cnt) : walk_slot;
    ram_we    = 1'b0;
    ram_waddr = eval_slot;
    ram_wdata = ram_rdata;
    if (accept && req.mode == MODE_INSERT && in_range) begin
      ram_we    = 1'b1;
      ram_waddr = ins_slot;
      ram_wdata = {{AGE_BITS{1'b0}}, req.instr_count};
    end else if (state == S_AGE1 && eval_valid) begin
      ram_we    = 1'b1;
      ram_wdata = {ws_ref, rd_age[AGE_BITS-1:1], rd_last_use};
    end else if (state == S_WSET && eval_valid && ws_ref) begin
      ram_we    = 1'b1;
      ram_wdata = {rd_age, now_time};
    end
  end

  // slot to frame and frame to slot maps
  always_ff @(posedge clk) begin
    if (accept && req.mode == MODE_INSERT && in_range && ins_append) begin
      slot_frame[ins_slot]  <= frame_idx;
      frame_slot[frame_idx] <= ins_slot;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy           <= POL_FIFO;
      nru_clear_period <= TIME_W'(50);
      working_set_tau  <= TIME_W'(50);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:     policy <= cfg_data[2:0];
        CFG_NRU_PERIOD: nru_clear_period <= cfg_data[TIME_W-1:0];
        CFG_WS_TAU:     working_set_tau <= cfg_data[TIME_W-1:0];
        default:        ;
      endcase
    end
  end

  // scan and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      frame_queued    <= '0;
      slot_referenced <= '0;
      slot_modified   <= '0;
      queue_head      <= '0;
      queue_count     <= '0;
      scan_hand       <= '0;
      last_clear_time <= '0;
      eval_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // output register fill and drain
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= acc_state;
            res_status <= acc_status;
            now_time   <= req.instr_count;
            case (req.mode)
              MODE_INSERT: begin
                if (in_range) begin
                  if (ins_append) begin
                    frame_queued[frame_idx] <= 1'b1;
                    queue_count <= queue_count + CNT_W'(1);
                  end
                  slot_referenced[ins_slot] <= 1'b0;
                  slot_modified[ins_slot]   <= 1'b0;
                end
              end
              MODE_ACCESS: begin
                if (in_range && frame_queued[frame_idx]) begin
                  slot_referenced[frame_slot[frame_idx]] <= 1'b1;
                  if (req.is_write) begin
                    slot_modified[frame_slot[frame_idx]] <= 1'b1;
                  end
                end
              end
              MODE_SELECT: begin
                if (queue_count != '0) begin
                  scan_hand  <= start_pos;
                  issue_pos  <= start_pos;
                  issue_cnt  <= '0;
                  eval_valid <= 1'b0;
                  have_best  <= 1'b0;
                  best_cls   <= 3'd4;
                  best_pos   <= start_pos;
                  case (policy)
                    POL_CLOCK, POL_NRU, POL_AGING, POL_WSET: ;
                    default: begin
                      // fifo: pop the head
                      res_slot <= queue_head;
                      frame_queued[slot_frame[queue_head]] <= 1'b0;
                      queue_head <= (queue_head == SLOT_W'(NUM_FRAMES - 1)) ? '0
                                    : queue_head + SLOT_W'(1);
                      queue_count <= queue_count - CNT_W'(1);
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        S_CLOCK: begin
          // second chance sweep from the hand
          scan_hand <= next_pos(scan_hand, queue_count);
          if (!slot_referenced[hand_slot]) begin
            res_slot <= hand_slot;
            state    <= S_DONE;
          end else begin
            slot_referenced[hand_slot] <= 1'b0;
          end
        end
        S_NRU: begin
          // lowest class, first from the hand
          issue_pos <= next_pos(issue_pos, queue_count);
          issue_cnt <= issue_cnt + CNT_W'(1);
          if (nru_cls < best_cls) begin
            best_cls <= nru_cls;
          end
          best_pos <= nru_pos;
          if (issue_cnt == queue_count - CNT_W'(1)) begin
            scan_hand <= next_pos(nru_pos, queue_count);
            res_slot  <= slot_of(queue_head, nru_pos);
            state     <= S_DONE;
            if ((now_time - last_clear_time) >= nru_clear_period) begin
              slot_referenced <= '0;
              last_clear_time <= now_time;
            end
          end
        end
        S_AGE1: begin
          // shift referenced bits into the age counters in queue order
          if (issue_more) begin
            issue_cnt  <= issue_cnt + CNT_W'(1);
            eval_slot  <= slot_of(queue_head, issue_cnt);
            eval_valid <= 1'b1;
          end else begin
            eval_valid <= 1'b0;
          end
          if (eval_valid) begin
            slot_referenced[eval_slot] <= 1'b0;
          end
          if (!issue_more && !eval_valid) begin
            state     <= S_AGE2;
            issue_cnt <= '0;
            issue_pos <= scan_hand;
          end
        end
        S_AGE2, S_WSET: begin
          // read one slot ahead, evaluate the returned one
          if (issue_more) begin
            issue_pos  <= next_pos(issue_pos, queue_count);
            issue_cnt  <= issue_cnt + CNT_W'(1);
            eval_pos   <= issue_pos;
            eval_slot  <= walk_slot;
          end
          eval_valid <= issue_more && !(eval_valid && state == S_WSET && ws_hit);
          if (eval_valid) begin
            if (state == S_WSET && ws_ref) begin
              slot_referenced[eval_slot] <= 1'b0;
            end
            if (state == S_WSET && ws_hit) begin
              scan_hand  <= next_pos(eval_pos, queue_count);
              res_slot   <= eval_slot;
              state      <= S_DONE;
            end else begin
              have_best <= 1'b1;
              best_pos  <= keep_pos;
              if (take) begin
                best_val <= cand_val;
              end
              if (eval_last) begin
                scan_hand <= next_pos(keep_pos, queue_count);
                res_slot  <= slot_of(queue_head, keep_pos);
                state     <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          // hand the result to the output register
          if (out_free) begin
            out_status <= res_status;
            out_frame  <= (res_status == ST_VICTIM) ? 4'(slot_frame[res_slot]) : 4'd0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // queue bookkeeping stays consistent
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(queue_count) <= NUM_FRAMES)
    else $error("queue count above frame count");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(frame_queued) == int'(queue_count))
    else $error("tracked frames differ from queue count");

  // a scan write never hits the slot being read ahead
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_AGE1 || state == S_WSET) && issue_more) |-> ram_waddr != ram_raddr)
    else $error("ram read and write to the same slot");

  // scans only run on a filled queue
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOCK || state == S_NRU || state == S_AGE1 || state == S_AGE2
     || state == S_WSET) |-> queue_count != '0)
    else $error("scan on empty queue");

  a_done_hands_off: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not delivered to output register");

endmodule
`default_nettype wire

// ----- sim/tb_page_replacement_victim_selector_core.sv -----
// tb_page_replacement_victim_selector_core: self-checking bench for the victim selector core
// depends on prvs_pkg, prvs_req_if, prvs_rsp_if and page_replacement_victim_selector_core
// a local model of the frame queue predicts each result; random traffic and stalls on both sides
`timescale 1ns / 1ps
module tb_page_replacement_victim_selector_core;
  import prvs_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  frame;
    logic        wr;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] victim;
  } outcome_t;

  localparam int RUN_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  prvs_req_if req ();
  prvs_rsp_if rsp ();

  page_replacement_victim_selector_core uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // model state of the frame queue
  logic [2:0]  m_policy;
  logic [31:0] m_period, m_tau;
  logic [3:0]  q_frame [NUM_FRAMES];
  logic        q_ref [NUM_FRAMES];
  logic        q_mod [NUM_FRAMES];
  logic [31:0] q_age [NUM_FRAMES];
  logic [31:0] q_last [NUM_FRAMES];
  logic        f_queued [NUM_FRAMES];
  int unsigned q_head, q_count, hand;
  logic [31:0] last_clear;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  bit failed = 0;
  bit req_taken = 0;
  bit quiet = 0;
  bit want_hold = 0;
  int send_gap = 0, recv_gap = 0, hold_left = 0;
  int cycles = 0;
  logic [31:0] clock_now = 0;

  function automatic int unsigned slot_at(int unsigned p);
    return (q_head + p) % NUM_FRAMES;
  endfunction

  function automatic int unsigned after(int unsigned p);
    return (p + 1 >= q_count) ? 0 : p + 1;
  endfunction

  function automatic int unsigned pick_clock();
    int unsigned s;
    for (int unsigned i = 0; i <= 2 * q_count; i++) begin
      s = slot_at(hand);
      hand = after(hand);
      if (!q_ref[s]) return s;
      q_ref[s] = 1'b0;
    end
    return slot_at(0);
  endfunction

  function automatic int unsigned pick_nru(logic [31:0] now);
    int unsigned best_pos, best_class, p, s, c;
    best_pos = hand;
    best_class = 4;
    p = hand;
    for (int unsigned i = 0; i < q_count; i++) begin
      s = slot_at(p);
      c = {q_ref[s], q_mod[s]};
      if (c < best_class) begin
        best_class = c;
        best_pos = p;
      end
      p = after(p);
    end
    s = slot_at(best_pos);
    hand = after(best_pos);
    if (now - last_clear >= m_period) begin
      for (int unsigned i = 0; i < q_count; i++) q_ref[slot_at(i)] = 1'b0;
      last_clear = now;
    end
    return s;
  endfunction

  function automatic int unsigned pick_aging();
    int unsigned s, p, best_pos;
    logic [31:0] best;
    p = hand;
    best_pos = hand;
    best = '1;
    for (int unsigned i = 0; i < q_count; i++) begin
      s = slot_at(i);
      q_age[s] = {q_ref[s], q_age[s][31:1]};
      q_ref[s] = 1'b0;
    end
    for (int unsigned i = 0; i < q_count; i++) begin
      if (i == 0 || q_age[slot_at(p)] < best) begin
        best = q_age[slot_at(p)];
        best_pos = p;
      end
      p = after(p);
    end
    hand = after(best_pos);
    return slot_at(best_pos);
  endfunction

  function automatic int unsigned pick_wset(logic [31:0] now);
    int unsigned s, p, best_pos;
    logic [31:0] idle, best_idle;
    best_pos = hand;
    best_idle = 0;
    for (int unsigned i = 0; i < q_count; i++) begin
      p = hand;
      s = slot_at(p);
      if (q_ref[s]) begin
        q_last[s] = now;
        q_ref[s] = 1'b0;
      end else if (now - q_last[s] >= m_tau) begin
        hand = after(p);
        return s;
      end
      idle = now - q_last[s];
      if (i == 0 || idle > best_idle) begin
        best_idle = idle;
        best_pos = p;
      end
      hand = after(p);
    end
    hand = after(best_pos);
    return slot_at(best_pos);
  endfunction

  // work out the outcome of one accepted request and update the model
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int unsigned s;
    bit found;
    o.status = ST_DONE;
    o.victim = '0;
    s = 0;
    if (r.mode == MODE_INSERT) begin
      if (!f_queued[r.frame]) begin
        s = slot_at(q_count);
        q_frame[s] = r.frame;
        f_queued[r.frame] = 1'b1;
        q_count++;
      end else begin
        for (int unsigned p = 0; p < q_count; p++)
          if (q_frame[slot_at(p)] == r.frame) s = slot_at(p);
      end
      q_ref[s] = 1'b0;
      q_mod[s] = 1'b0;
      q_age[s] = '0;
      q_last[s] = r.now;
    end else if (r.mode == MODE_ACCESS) begin
      found = 0;
      if (f_queued[r.frame])
        for (int unsigned p = 0; p < q_count; p++)
          if (!found && q_frame[slot_at(p)] == r.frame) begin
            s = slot_at(p);
            found = 1;
          end
      if (found) begin
        q_ref[s] = 1'b1;
        if (r.wr) q_mod[s] = 1'b1;
      end else begin
        o.status = ST_UNTRACKED;
      end
    end else if (r.mode == MODE_SELECT) begin
      if (q_count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        if (hand >= q_count) hand = 0;
        o.status = ST_VICTIM;
        case (m_policy)
          POL_CLOCK: s = pick_clock();
          POL_NRU:   s = pick_nru(r.now);
          POL_AGING: s = pick_aging();
          POL_WSET:  s = pick_wset(r.now);
          default: begin
            s = slot_at(0);
            f_queued[q_frame[s]] = 1'b0;
            q_head = (q_head + 1) % NUM_FRAMES;
            q_count--;
          end
        endcase
        o.victim = q_frame[s];
      end
    end
    return o;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        req.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        req.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        req.valid <= 1'b1;
        req.mode <= r.mode;
        req.frame_index <= r.frame;
        req.is_write <= r.wr;
        req.instr_count <= r.now;
      end else begin
        req.valid <= 1'b0;
      end
    end
    req_taken = 0;
  end

  // result receiver with burst stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (want_hold && hold_left == 0) begin
      want_hold = 0;
      hold_left = 400;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 18) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // request and result monitors
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      request_t r;
      r = '{req.mode, req.frame_index, req.is_write, req.instr_count};
      expected_outcomes = {expected_outcomes, apply_request(r)};
      req_taken = 1;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result status %0d victim %0d", $time,
                 rsp.status, rsp.victim_frame);
        failed = 1;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (rsp.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
        if (rsp.victim_frame !== e.victim)
          $display("%0t: victim expected %0d actual %0d", $time, e.victim, rsp.victim_frame);
        if (rsp.status !== e.status || rsp.victim_frame !== e.victim) failed = 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_request(logic [1:0] mode, logic [3:0] frame, logic wr, logic [31:0] now);
    request_t r;
    r = '{mode, frame, wr, now};
    pending_requests = {pending_requests, r};
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_POLICY) m_policy = val[2:0];
    else if (idx == CFG_NRU_PERIOD) m_period = val;
    else if (idx == CFG_WS_TAU) m_tau = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_all();
    wait (pending_requests.size() == 0 && expected_outcomes.size() == 0 && !req.valid);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 120);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned pick;
    logic [1:0] mode;
    logic [2:0] pol_list [12];
    pol_list = '{POL_FIFO, POL_CLOCK, POL_FIFO, POL_NRU, POL_FIFO, POL_AGING,
                 POL_FIFO, POL_WSET, 3'd5, POL_NRU, 3'd7, POL_WSET};
    m_policy = POL_FIFO;
    m_period = 32'd50;
    m_tau = 32'd50;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      q_frame[i] = '0; q_ref[i] = 0; q_mod[i] = 0;
      q_age[i] = '0; q_last[i] = '0; f_queued[i] = 0;
    end
    q_head = 0; q_count = 0; hand = 0; last_clear = '0;
    req.valid = 1'b0; req.mode = '0; req.frame_index = '0;
    req.is_write = 1'b0; req.instr_count = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty select, inserts, duplicate, absent access, unused mode, pops
    add_request(MODE_SELECT, 4'd0, 1'b0, 32'd0);
    add_request(MODE_ACCESS, 4'd3, 1'b1, 32'd1);
    add_request(MODE_INSERT, 4'd0, 1'b0, 32'd2);
    add_request(MODE_INSERT, 4'd15, 1'b1, 32'hFFFF_FFFF);
    add_request(MODE_INSERT, 4'd7, 1'b0, 32'd4);
    add_request(MODE_INSERT, 4'd0, 1'b0, 32'd5);
    add_request(MODE_ACCESS, 4'd15, 1'b1, 32'd6);
    add_request(MODE_ACCESS, 4'd7, 1'b0, 32'd7);
    add_request(2'd3, 4'd9, 1'b1, 32'h8000_0000);
    add_request(MODE_SELECT, 4'd15, 1'b1, 32'd9);
    add_request(MODE_SELECT, 4'd0, 1'b0, 32'd10);
    add_request(MODE_SELECT, 4'd0, 1'b0, 32'd11);
    add_request(MODE_SELECT, 4'd0, 1'b0, 32'd12);
    add_request(MODE_ACCESS, 4'd0, 1'b0, 32'd13);
    drain_all();

    set_reg(CFG_NRU_PERIOD, 32'd1);
    set_reg(CFG_WS_TAU, 32'hFFFF_FFFF);
    for (int ph = 0; ph < 12; ph++) begin
      set_reg(CFG_POLICY, {29'd0, pol_list[ph]});
      if (ph > 0) begin
        set_reg(CFG_NRU_PERIOD, pick_limit());
        set_reg(CFG_WS_TAU, pick_limit());
      end
      if (ph == 3) want_hold = 1;
      if (ph == 11) quiet = 1;
      for (int n = 0; n < 140; n++) begin
        pick = $urandom_range(0, 99);
        if (pol_list[ph] == POL_FIFO || pol_list[ph] > POL_WSET)
          mode = (pick < 30) ? MODE_INSERT : (pick < 55) ? MODE_ACCESS :
                 (pick < 97) ? MODE_SELECT : 2'd3;
        else
          mode = (pick < 20) ? MODE_INSERT : (pick < 60) ? MODE_ACCESS :
                 (pick < 97) ? MODE_SELECT : 2'd3;
        if ($urandom_range(0, 19) == 0) clock_now = $urandom();
        else clock_now = clock_now + $urandom_range(0, 40);
        add_request(mode, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), clock_now);
      end
      drain_all();
    end

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- page_replacement_victim_selector_core.f -----
rtl/prvs_pkg.sv
rtl/prvs_req_if.sv
rtl/prvs_rsp_if.sv
rtl/prvs_ram.sv
rtl/page_replacement_victim_selector_core.sv
sim/tb_page_replacement_victim_selector_core.sv
